// ----- rtl/core/pdcm_pkg.sv -----
// Shared types, constants and codes of the periodic deadline cadence monitor.
// Depends on nothing; every other file of the block refers to it by scoped name.
package pdcm_pkg;

    // Depth of each telemetry window, and the widths that follow from it.
    localparam int WIN_DEPTH = 512;
    localparam int WIN_AW    = $clog2(WIN_DEPTH);
    localparam int FILL_W    = $clog2(WIN_DEPTH + 1);

    localparam int T_W   = 63;   // time stamps
    localparam int V_W   = 40;   // interval, phase, jitter and error samples
    localparam int C_W   = 32;   // saturating counters
    localparam int DL_W  = 64;   // deadline, which may pass the 63-bit time range
    localparam int BIT_W = $clog2(V_W);

    // Operation codes of an input item.
    localparam logic [1:0] OP_START  = 2'd0;
    localparam logic [1:0] OP_STOP   = 2'd1;
    localparam logic [1:0] OP_RESUME = 2'd2;
    localparam logic [1:0] OP_POLL   = 2'd3;

    // Configuration register indexes.
    localparam logic REG_INTERVAL = 1'b0;
    localparam logic REG_PHASE    = 1'b1;

    localparam logic [V_W-1:0] MIN_INTERVAL   = 40'd1000000;
    localparam logic [V_W-1:0] RESET_INTERVAL = 40'd1000000;

    // Percentile rank: ceil(95n/100) = (95n + 99) / 100, the division done as a
    // multiplication by a rounded-up reciprocal, exact for these operand widths.
    localparam int RANK_NUM   = 95;
    localparam int RANK_BIAS  = 99;
    localparam int RANK_SHIFT = 26;
    localparam int RANK_MULT  = 671089;
    localparam int RANK_M_W   = 20;
    localparam int RANK_X_W   = FILL_W + 7;

    typedef struct packed {
        logic [1:0]     op;
        logic [T_W-1:0] now;
        logic [T_W-1:0] now_unix;
        logic [T_W-1:0] actual;
    } cmd_t;

    typedef struct packed {
        logic           start;
        logic [T_W-1:0] dividend;
        logic [V_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic           clear;
        logic           push;
        logic [V_W-1:0] data;
    } win_cmd_t;

    typedef struct packed {
        logic           due;
        logic [T_W-1:0] sched;
        logic [T_W-1:0] sched_unix;
        logic [C_W-1:0] missed_now;
        logic [C_W-1:0] sched_total;
        logic [C_W-1:0] missed_total;
        logic [V_W-1:0] jitter;
        logic [V_W-1:0] jitter_p95;
        logic [V_W-1:0] err_p95;
    } result_t;

endpackage

// ----- rtl/core/pdcm_front.sv -----
// Front end: takes input transactions, tags them by operation and holds them
// in a two-entry queue for the back end. Depends on pdcm_pkg.
module pdcm_front
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      push,
    output logic                      full,
    input  logic [1:0]                op,
    input  logic [pdcm_pkg::T_W-1:0]  now_ns,
    input  logic [pdcm_pkg::T_W-1:0]  now_unix_ns,
    input  logic [pdcm_pkg::T_W-1:0]  actual_start_unix_ns,
    output logic                      cmd_valid,
    output pdcm_pkg::cmd_t            cmd,
    input  logic                      cmd_take
);

    pdcm_pkg::cmd_t q_mem [2];
    pdcm_pkg::cmd_t in_cmd;
    logic           wr_ptr_reg;
    logic           rd_ptr_reg;
    logic [1:0]     cnt_reg;
    logic [1:0]     cnt_next;
    logic           wr_en;
    logic           rd_en;

    always_comb
    begin
        in_cmd.op       = op;
        in_cmd.now      = now_ns;
        in_cmd.now_unix = now_unix_ns;
        // Only a poll carries an acquisition stamp; other operations keep none.
        in_cmd.actual   = (op == pdcm_pkg::OP_POLL) ? actual_start_unix_ns : '0;
    end

    assign full      = (cnt_reg == 2'd2);
    assign cmd_valid = (cnt_reg != 2'd0);
    assign cmd       = q_mem[rd_ptr_reg];
    assign wr_en     = push && !full;
    assign rd_en     = cmd_take && cmd_valid;

    always_comb
    begin
        cnt_next = cnt_reg;
        if (wr_en && !rd_en)
        begin
            cnt_next = cnt_reg + 2'd1;
        end
        else if (rd_en && !wr_en)
        begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (wr_en)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (rd_en)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            q_mem[wr_ptr_reg] <= in_cmd;
        end
    end

endmodule

// ----- rtl/core/pdcm_div.sv -----
// Restoring divider, one quotient bit per cycle, giving the remainder and a
// quotient saturated to 32 bits. Depends on pdcm_pkg.
module pdcm_div
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  pdcm_pkg::div_req_t       req,
    output logic                     busy,
    output logic                     done,
    output logic [pdcm_pkg::V_W-1:0] rem,
    output logic [pdcm_pkg::C_W-1:0] quo_sat
);

    localparam int T_W   = pdcm_pkg::T_W;
    localparam int V_W   = pdcm_pkg::V_W;
    localparam int C_W   = pdcm_pkg::C_W;
    localparam int STEPW = $clog2(T_W + 1);

    logic             busy_reg;
    logic             done_reg;
    logic [STEPW-1:0] step_reg;
    logic [T_W-1:0]   dvd_reg;
    logic [V_W-1:0]   dsr_reg;
    logic [V_W-1:0]   rem_reg;
    logic [C_W-1:0]   quo_reg;
    logic             ovf_reg;
    logic [V_W:0]     partial;
    logic [V_W:0]     diff;
    logic             qbit;

    assign partial = {rem_reg, dvd_reg[T_W-1]};
    assign diff    = partial - {1'b0, dsr_reg};
    assign qbit    = (partial >= {1'b0, dsr_reg});

    assign busy    = busy_reg;
    assign done    = done_reg;
    assign rem     = rem_reg;
    assign quo_sat = ovf_reg ? '1 : quo_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start && !busy_reg)
            begin
                busy_reg <= 1'b1;
                step_reg <= STEPW'(T_W);
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg - STEPW'(1);
                if (step_reg == STEPW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start && !busy_reg)
        begin
            dvd_reg <= req.dividend;
            dsr_reg <= req.divisor;
            rem_reg <= '0;
            quo_reg <= '0;
            ovf_reg <= 1'b0;
        end
        else if (busy_reg)
        begin
            dvd_reg <= {dvd_reg[T_W-2:0], 1'b0};
            rem_reg <= qbit ? diff[V_W-1:0] : partial[V_W-1:0];
            // A one shifted out of the top means the quotient passed 32 bits.
            ovf_reg <= ovf_reg | quo_reg[C_W-1];
            quo_reg <= {quo_reg[C_W-2:0], qbit};
        end
    end

endmodule

// ----- rtl/core/pdcm_window.sv -----
// Sliding window of the newest samples with a 95th percentile search: a
// bitwise search on the value, each step a counting sweep over the memory.
// Depends on pdcm_pkg.
module pdcm_window
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  pdcm_pkg::win_cmd_t       cmd,
    output logic                     busy,
    output logic [pdcm_pkg::V_W-1:0] p95
);

    localparam int DEPTH = pdcm_pkg::WIN_DEPTH;
    localparam int AW    = pdcm_pkg::WIN_AW;
    localparam int FW    = pdcm_pkg::FILL_W;
    localparam int V_W   = pdcm_pkg::V_W;
    localparam int BW    = pdcm_pkg::BIT_W;
    localparam int XW    = pdcm_pkg::RANK_X_W;
    localparam int PW    = XW + pdcm_pkg::RANK_M_W;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SCALE  = 3'd1;
    localparam logic [2:0] S_RANK   = 3'd2;
    localparam logic [2:0] S_SWEEP  = 3'd3;
    localparam logic [2:0] S_DRAIN  = 3'd4;
    localparam logic [2:0] S_DECIDE = 3'd5;

    localparam logic [V_W-1:0] ONE = V_W'(1);

    logic [V_W-1:0] mem [DEPTH];
    logic [2:0]     state_reg;
    logic [AW-1:0]  head_reg;
    logic [FW-1:0]  fill_reg;
    logic [AW-1:0]  addr_reg;
    logic [FW-1:0]  cnt_reg;
    logic [FW-1:0]  rank_reg;
    logic [XW-1:0]  x_reg;
    logic [BW-1:0]  bit_reg;
    logic [V_W-1:0] ans_reg;
    logic [V_W-1:0] p95_reg;
    logic [V_W-1:0] rd_data_reg;
    logic           rd_vld_reg;
    logic [V_W-1:0] probe;
    logic [V_W-1:0] bit_val;
    logic [PW-1:0]  prod;
    logic           last_addr;
    logic           do_push;

    assign bit_val   = ONE << bit_reg;
    // Largest value whose bits above the current one match the answer so far and whose current bit is clear.
    assign probe     = ans_reg | (bit_val - ONE);
    assign prod      = PW'(x_reg) * PW'(pdcm_pkg::RANK_MULT);
    assign last_addr = (FW'(addr_reg) == fill_reg - FW'(1));
    assign do_push   = cmd.push && (state_reg == S_IDLE);
    assign busy      = (state_reg != S_IDLE);
    assign p95       = p95_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            head_reg   <= '0;
            fill_reg   <= '0;
            p95_reg    <= '0;
            rd_vld_reg <= 1'b0;
            cnt_reg    <= '0;
        end
        else
        begin
            rd_vld_reg <= (state_reg == S_SWEEP);
            if (rd_vld_reg && (rd_data_reg <= probe))
            begin
                cnt_reg <= cnt_reg + FW'(1);
            end
            if (cmd.clear)
            begin
                state_reg <= S_IDLE;
                head_reg  <= '0;
                fill_reg  <= '0;
                p95_reg   <= '0;
            end
            else
            begin
                unique case (state_reg)
                    S_IDLE:
                    begin
                        if (do_push)
                        begin
                            head_reg <= (head_reg == AW'(DEPTH - 1)) ?
                                        '0 : head_reg + AW'(1);
                            if (fill_reg != FW'(DEPTH))
                            begin
                                fill_reg <= fill_reg + FW'(1);
                            end
                            state_reg <= S_SCALE;
                        end
                    end
                    S_SCALE:
                    begin
                        state_reg <= S_RANK;
                    end
                    S_RANK:
                    begin
                        cnt_reg   <= '0;
                        state_reg <= S_SWEEP;
                    end
                    S_SWEEP:
                    begin
                        if (last_addr)
                        begin
                            state_reg <= S_DRAIN;
                        end
                    end
                    S_DRAIN:
                    begin
                        state_reg <= S_DECIDE;
                    end
                    S_DECIDE:
                    begin
                        cnt_reg <= '0;
                        if (bit_reg == '0)
                        begin
                            p95_reg   <= (cnt_reg >= rank_reg) ? ans_reg
                                                               : (ans_reg | bit_val);
                            state_reg <= S_IDLE;
                        end
                        else
                        begin
                            state_reg <= S_SWEEP;
                        end
                    end
                    default:
                    begin
                        state_reg <= S_IDLE;
                    end
                endcase
            end
        end
    end

    // Search datapath and memory; no reset needed.
    always_ff @(posedge clk)
    begin
        if (do_push && !cmd.clear)
        begin
            mem[head_reg] <= cmd.data;
        end
        rd_data_reg <= mem[addr_reg];
        case (state_reg)
            S_SCALE:
            begin
                x_reg <= XW'(fill_reg) * XW'(pdcm_pkg::RANK_NUM) + XW'(pdcm_pkg::RANK_BIAS);
            end
            S_RANK:
            begin
                rank_reg <= prod[pdcm_pkg::RANK_SHIFT +: FW];
                bit_reg  <= BW'(V_W - 1);
                ans_reg  <= '0;
                addr_reg <= '0;
            end
            S_SWEEP:
            begin
                if (!last_addr)
                begin
                    addr_reg <= addr_reg + AW'(1);
                end
            end
            S_DECIDE:
            begin
                // Too few samples at or below the probe: the answer has this bit set.
                if (cnt_reg < rank_reg)
                begin
                    ans_reg <= ans_reg | bit_val;
                end
                bit_reg  <= bit_reg - BW'(1);
                addr_reg <= '0;
            end
            default:
            begin
            end
        endcase
    end

endmodule

// ----- rtl/core/pdcm_back.sv -----
// Back end: the schedule state machine. It runs the divider, updates the
// deadline, anchors and totals, feeds both windows and assembles each result.
// Depends on pdcm_pkg.
module pdcm_back
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic [pdcm_pkg::V_W-1:0] interval,
    input  logic [pdcm_pkg::V_W-1:0] phase,
    input  logic                     cmd_valid,
    input  pdcm_pkg::cmd_t           cmd,
    output logic                     cmd_take,
    output pdcm_pkg::div_req_t       div_req,
    input  logic                     div_done,
    input  logic [pdcm_pkg::V_W-1:0] div_rem,
    input  logic [pdcm_pkg::C_W-1:0] div_quo,
    output pdcm_pkg::win_cmd_t       jw_cmd,
    output pdcm_pkg::win_cmd_t       ew_cmd,
    input  logic                     jw_busy,
    input  logic                     ew_busy,
    input  logic [pdcm_pkg::V_W-1:0] jw_p95,
    input  logic [pdcm_pkg::V_W-1:0] ew_p95,
    output logic                     res_valid,
    output pdcm_pkg::result_t        res,
    input  logic                     res_ready
);

    localparam int T_W  = pdcm_pkg::T_W;
    localparam int V_W  = pdcm_pkg::V_W;
    localparam int C_W  = pdcm_pkg::C_W;
    localparam int DL_W = pdcm_pkg::DL_W;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_DIV   = 3'd1;
    localparam logic [2:0] ST_SPAN  = 3'd2;
    localparam logic [2:0] ST_STAMP = 3'd3;
    localparam logic [2:0] ST_WAIT  = 3'd4;
    localparam logic [2:0] ST_EMIT  = 3'd5;

    logic [2:0]      state_reg;
    pdcm_pkg::cmd_t  cmd_reg;
    logic            running_reg;
    logic [DL_W-1:0] next_reg;
    logic [T_W-1:0]  anc_mono_reg;
    logic [T_W-1:0]  anc_unix_reg;
    logic [T_W-1:0]  prev_reg;
    logic [C_W-1:0]  sched_cnt_reg;
    logic [C_W-1:0]  miss_cnt_reg;
    logic            due_reg;
    logic [T_W-1:0]  sched_reg;
    logic [T_W-1:0]  sunix_reg;
    logic [C_W-1:0]  mnow_reg;
    logic [V_W-1:0]  jit_reg;
    logic [T_W-1:0]  eff_reg;
    logic [T_W-1:0]  off_reg;
    logic [T_W-1:0]  dpos_reg;
    logic [T_W-1:0]  dneg_reg;
    logic            ge_reg;

    logic            due_now;
    logic [DL_W-1:0] iv64;
    logic [DL_W-1:0] err;
    logic [V_W-1:0]  err_sat;
    logic [DL_W-1:0] unix_sum;
    logic [C_W:0]    miss_sum;

    assign iv64    = DL_W'(interval);
    assign due_now = running_reg && ({1'b0, cmd.now} >= next_reg);

    always_comb
    begin
        if (ge_reg)
        begin
            err = (DL_W'(dpos_reg) >= iv64) ? DL_W'(dpos_reg) - iv64
                                            : iv64 - DL_W'(dpos_reg);
        end
        else
        begin
            err = DL_W'(dneg_reg) + iv64;
        end
        err_sat = (err[DL_W-1:V_W] != '0) ? '1 : err[V_W-1:0];
    end

    assign unix_sum = DL_W'(anc_unix_reg) + DL_W'(off_reg);
    assign miss_sum = {1'b0, miss_cnt_reg} + {1'b0, mnow_reg};

    assign cmd_take = (state_reg == ST_IDLE) && cmd_valid;

    always_comb
    begin
        div_req.start    = cmd_take && ((cmd.op == pdcm_pkg::OP_START) ||
                                        ((cmd.op == pdcm_pkg::OP_POLL) && due_now));
        div_req.dividend = (cmd.op == pdcm_pkg::OP_START) ? T_W'(phase)
                                                          : cmd.now - next_reg[T_W-1:0];
        div_req.divisor  = interval;

        jw_cmd.clear = (state_reg == ST_DIV) && div_done &&
                       (cmd_reg.op == pdcm_pkg::OP_START);
        jw_cmd.push  = (state_reg == ST_STAMP);
        jw_cmd.data  = jit_reg;
        ew_cmd.clear = jw_cmd.clear;
        // The first consumed deadline after an anchor has no earlier start to compare.
        ew_cmd.push  = (state_reg == ST_STAMP) && (prev_reg != '0);
        ew_cmd.data  = err_sat;

        res_valid        = (state_reg == ST_EMIT);
        res.due          = due_reg;
        res.sched        = sched_reg;
        res.sched_unix   = sunix_reg;
        res.missed_now   = mnow_reg;
        res.sched_total  = sched_cnt_reg;
        res.missed_total = miss_cnt_reg;
        res.jitter       = jit_reg;
        res.jitter_p95   = jw_p95;
        res.err_p95      = ew_p95;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            running_reg   <= 1'b0;
            next_reg      <= '0;
            anc_mono_reg  <= '0;
            anc_unix_reg  <= '0;
            prev_reg      <= '0;
            sched_cnt_reg <= '0;
            miss_cnt_reg  <= '0;
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (cmd_valid)
                    begin
                        unique case (cmd.op)
                            pdcm_pkg::OP_START:
                            begin
                                state_reg <= ST_DIV;
                            end
                            pdcm_pkg::OP_STOP:
                            begin
                                running_reg <= 1'b0;
                                state_reg   <= ST_EMIT;
                            end
                            pdcm_pkg::OP_RESUME:
                            begin
                                if (running_reg)
                                begin
                                    anc_mono_reg <= cmd.now;
                                    anc_unix_reg <= cmd.now_unix;
                                    next_reg     <= DL_W'(cmd.now) + iv64;
                                    prev_reg     <= '0;
                                end
                                state_reg <= ST_EMIT;
                            end
                            default:
                            begin
                                state_reg <= due_now ? ST_DIV : ST_EMIT;
                            end
                        endcase
                    end
                end
                ST_DIV:
                begin
                    if (div_done)
                    begin
                        if (cmd_reg.op == pdcm_pkg::OP_START)
                        begin
                            running_reg   <= 1'b1;
                            anc_mono_reg  <= cmd_reg.now;
                            anc_unix_reg  <= cmd_reg.now_unix;
                            next_reg      <= DL_W'(cmd_reg.now) + DL_W'(div_rem);
                            prev_reg      <= '0;
                            sched_cnt_reg <= '0;
                            miss_cnt_reg  <= '0;
                            state_reg     <= ST_EMIT;
                        end
                        else
                        begin
                            state_reg <= ST_SPAN;
                        end
                    end
                end
                ST_SPAN:
                begin
                    next_reg <= DL_W'(eff_reg) + iv64;
                    if (sched_cnt_reg != '1)
                    begin
                        sched_cnt_reg <= sched_cnt_reg + C_W'(1);
                    end
                    miss_cnt_reg <= miss_sum[C_W] ? '1 : miss_sum[C_W-1:0];
                    state_reg    <= ST_STAMP;
                end
                ST_STAMP:
                begin
                    prev_reg  <= cmd_reg.actual;
                    state_reg <= ST_WAIT;
                end
                ST_WAIT:
                begin
                    if (!jw_busy && !ew_busy)
                    begin
                        state_reg <= ST_EMIT;
                    end
                end
                ST_EMIT:
                begin
                    if (res_ready)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // Per-item datapath registers.
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_reg   <= cmd;
                    due_reg   <= 1'b0;
                    sched_reg <= '0;
                    sunix_reg <= '0;
                    mnow_reg  <= '0;
                    jit_reg   <= '0;
                end
            end
            ST_DIV:
            begin
                if (div_done && (cmd_reg.op != pdcm_pkg::OP_START))
                begin
                    // The effective deadline is the latest one not after now.
                    eff_reg  <= cmd_reg.now - T_W'(div_rem);
                    jit_reg  <= div_rem;
                    mnow_reg <= div_quo;
                    due_reg  <= 1'b1;
                end
            end
            ST_SPAN:
            begin
                sched_reg <= eff_reg;
                off_reg   <= (eff_reg >= anc_mono_reg) ? eff_reg - anc_mono_reg : '0;
                dpos_reg  <= cmd_reg.actual - prev_reg;
                dneg_reg  <= prev_reg - cmd_reg.actual;
                ge_reg    <= (cmd_reg.actual >= prev_reg);
            end
            ST_STAMP:
            begin
                sunix_reg <= unix_sum[T_W] ? '1 : unix_sum[T_W-1:0];
            end
            default:
            begin
            end
        endcase
    end

endmodule

// ----- rtl/core/periodic_deadline_cadence_monitor_unit.sv -----
// Top level of the periodic deadline cadence monitor: configuration registers,
// front end, divider, two telemetry windows, back end and result queue.
// Depends on pdcm_pkg, pdcm_front, pdcm_div, pdcm_window and pdcm_back.
//
//   channel   direction  handshake               payload
//   input     in         push / full             op, now_ns, now_unix_ns,
//                                                actual_start_unix_ns
//   result    out        empty / pop             due ... interval_error_p95_ns
//   config    in         cfg_valid / cfg_ready   cfg_index, cfg_data
//
// Stop, resume and a poll that is not due go straight to the result stage. Start
// is bound by the 63-step divider. A due poll runs the divider as well and then
// waits for both windows: the percentile search sweeps the filled part of the
// window memory once per result bit. Reset needs no clearing pass.
// Two input transactions and two results can wait; each side stalls alone.
module periodic_deadline_cadence_monitor_unit
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      push,
    output logic                      full,
    input  logic [1:0]                op,
    input  logic [pdcm_pkg::T_W-1:0]  now_ns,
    input  logic [pdcm_pkg::T_W-1:0]  now_unix_ns,
    input  logic [pdcm_pkg::T_W-1:0]  actual_start_unix_ns,
    output logic                      empty,
    input  logic                      pop,
    output logic                      due,
    output logic [pdcm_pkg::T_W-1:0]  scheduled_ns,
    output logic [pdcm_pkg::T_W-1:0]  scheduled_unix_ns,
    output logic [pdcm_pkg::C_W-1:0]  missed_now,
    output logic [pdcm_pkg::C_W-1:0]  scheduled_total,
    output logic [pdcm_pkg::C_W-1:0]  missed_total,
    output logic [pdcm_pkg::V_W-1:0]  jitter_ns,
    output logic [pdcm_pkg::V_W-1:0]  jitter_p95_ns,
    output logic [pdcm_pkg::V_W-1:0]  interval_error_p95_ns,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic                      cfg_index,
    input  logic [pdcm_pkg::V_W-1:0]  cfg_data
);

    logic [pdcm_pkg::V_W-1:0] interval_reg;
    logic [pdcm_pkg::V_W-1:0] phase_reg;

    logic                     cmd_valid;
    logic                     cmd_take;
    pdcm_pkg::cmd_t           cmd;
    pdcm_pkg::div_req_t       div_req;
    logic                     div_busy;
    logic                     div_done;
    logic [pdcm_pkg::V_W-1:0] div_rem;
    logic [pdcm_pkg::C_W-1:0] div_quo;
    pdcm_pkg::win_cmd_t       jw_cmd;
    pdcm_pkg::win_cmd_t       ew_cmd;
    logic                     jw_busy;
    logic                     ew_busy;
    logic [pdcm_pkg::V_W-1:0] jw_p95;
    logic [pdcm_pkg::V_W-1:0] ew_p95;
    logic                     res_valid;
    logic                     res_ready;
    pdcm_pkg::result_t        res;

    pdcm_pkg::result_t        oq_mem [2];
    pdcm_pkg::result_t        oq_head;
    logic                     oq_wr_reg;
    logic                     oq_rd_reg;
    logic [1:0]               oq_cnt_reg;
    logic                     oq_wr_en;
    logic                     oq_rd_en;

    // Configuration: always ready; a short interval is clamped on the write.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            interval_reg <= pdcm_pkg::RESET_INTERVAL;
            phase_reg    <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                pdcm_pkg::REG_INTERVAL:
                begin
                    interval_reg <= (cfg_data < pdcm_pkg::MIN_INTERVAL) ?
                                    pdcm_pkg::MIN_INTERVAL : cfg_data;
                end
                default:
                begin
                    phase_reg <= cfg_data;
                end
            endcase
        end
    end

    pdcm_front u_front
    (
        .clk                  (clk),
        .rst_n                (rst_n),
        .push                 (push),
        .full                 (full),
        .op                   (op),
        .now_ns               (now_ns),
        .now_unix_ns          (now_unix_ns),
        .actual_start_unix_ns (actual_start_unix_ns),
        .cmd_valid            (cmd_valid),
        .cmd                  (cmd),
        .cmd_take             (cmd_take)
    );

    pdcm_div u_div
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (div_req),
        .busy    (div_busy),
        .done    (div_done),
        .rem     (div_rem),
        .quo_sat (div_quo)
    );

    pdcm_window u_jitter_win
    (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (jw_cmd),
        .busy  (jw_busy),
        .p95   (jw_p95)
    );

    pdcm_window u_error_win
    (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (ew_cmd),
        .busy  (ew_busy),
        .p95   (ew_p95)
    );

    pdcm_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .interval  (interval_reg),
        .phase     (phase_reg),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_take  (cmd_take),
        .div_req   (div_req),
        .div_done  (div_done),
        .div_rem   (div_rem),
        .div_quo   (div_quo),
        .jw_cmd    (jw_cmd),
        .ew_cmd    (ew_cmd),
        .jw_busy   (jw_busy),
        .ew_busy   (ew_busy),
        .jw_p95    (jw_p95),
        .ew_p95    (ew_p95),
        .res_valid (res_valid),
        .res       (res),
        .res_ready (res_ready)
    );

    // Two-entry result queue.
    assign res_ready = (oq_cnt_reg != 2'd2);
    assign oq_wr_en  = res_valid && res_ready;
    assign empty     = (oq_cnt_reg == 2'd0);
    assign oq_rd_en  = pop && !empty;
    assign oq_head   = oq_mem[oq_rd_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            oq_wr_reg  <= 1'b0;
            oq_rd_reg  <= 1'b0;
            oq_cnt_reg <= 2'd0;
        end
        else
        begin
            if (oq_wr_en)
            begin
                oq_wr_reg <= !oq_wr_reg;
            end
            if (oq_rd_en)
            begin
                oq_rd_reg <= !oq_rd_reg;
            end
            if (oq_wr_en && !oq_rd_en)
            begin
                oq_cnt_reg <= oq_cnt_reg + 2'd1;
            end
            else if (oq_rd_en && !oq_wr_en)
            begin
                oq_cnt_reg <= oq_cnt_reg - 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (oq_wr_en)
        begin
            oq_mem[oq_wr_reg] <= res;
        end
    end

    assign due                   = oq_head.due;
    assign scheduled_ns          = oq_head.sched;
    assign scheduled_unix_ns     = oq_head.sched_unix;
    assign missed_now            = oq_head.missed_now;
    assign scheduled_total       = oq_head.sched_total;
    assign missed_total          = oq_head.missed_total;
    assign jitter_ns             = oq_head.jitter;
    assign jitter_p95_ns         = oq_head.jitter_p95;
    assign interval_error_p95_ns = oq_head.err_p95;

`ifndef SYNTHESIS
    a_div_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        div_req.start |-> !div_busy)
        else $error("divider started while busy");

    a_win_push_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (jw_cmd.push || ew_cmd.push) |->
            (!(jw_cmd.push && jw_busy) && !(ew_cmd.push && ew_busy)))
        else $error("window sample pushed during a percentile search");

    a_result_waits_for_search: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (!jw_busy && !ew_busy && !div_busy))
        else $error("result offered before its telemetry settled");

    a_queue_drains: assert property (@(posedge clk) disable iff (!rst_n)
        (oq_cnt_reg == 2'd1 && oq_rd_en && !oq_wr_en) |=> empty)
        else $error("result queue did not drain");
`endif

endmodule

// ----- tb/tb_periodic_deadline_cadence_monitor_unit.sv -----
// Self-checking testbench of the periodic deadline cadence monitor.
// Depends on pdcm_pkg and periodic_deadline_cadence_monitor_unit.
// Drives random and directed command streams through a queue and checks every result.
`timescale 1ns / 100ps

module tb_periodic_deadline_cadence_monitor_unit;

    localparam logic [63:0] MASK63   = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] MASK40   = 64'hFF_FFFF_FFFF;
    localparam logic [63:0] SAT32    = 64'hFFFF_FFFF;
    localparam logic [63:0] IV_FLOOR = 64'd1000000;
    localparam int JIT = 0;
    localparam int ERR = 1;

    logic clk;
    logic rst_n;
    logic push;
    logic full;
    logic [1:0] op;
    logic [pdcm_pkg::T_W-1:0] now_ns;
    logic [pdcm_pkg::T_W-1:0] now_unix_ns;
    logic [pdcm_pkg::T_W-1:0] actual_start_unix_ns;
    logic empty;
    logic pop;
    logic due;
    logic [pdcm_pkg::T_W-1:0] scheduled_ns;
    logic [pdcm_pkg::T_W-1:0] scheduled_unix_ns;
    logic [pdcm_pkg::C_W-1:0] missed_now;
    logic [pdcm_pkg::C_W-1:0] scheduled_total;
    logic [pdcm_pkg::C_W-1:0] missed_total;
    logic [pdcm_pkg::V_W-1:0] jitter_ns;
    logic [pdcm_pkg::V_W-1:0] jitter_p95_ns;
    logic [pdcm_pkg::V_W-1:0] interval_error_p95_ns;
    logic cfg_valid;
    logic cfg_ready;
    logic cfg_index;
    logic [pdcm_pkg::V_W-1:0] cfg_data;

    periodic_deadline_cadence_monitor_unit u_dut
    (
        .clk                   (clk),
        .rst_n                 (rst_n),
        .push                  (push),
        .full                  (full),
        .op                    (op),
        .now_ns                (now_ns),
        .now_unix_ns           (now_unix_ns),
        .actual_start_unix_ns  (actual_start_unix_ns),
        .empty                 (empty),
        .pop                   (pop),
        .due                   (due),
        .scheduled_ns          (scheduled_ns),
        .scheduled_unix_ns     (scheduled_unix_ns),
        .missed_now            (missed_now),
        .scheduled_total       (scheduled_total),
        .missed_total          (missed_total),
        .jitter_ns             (jitter_ns),
        .jitter_p95_ns         (jitter_p95_ns),
        .interval_error_p95_ns (interval_error_p95_ns),
        .cfg_valid             (cfg_valid),
        .cfg_ready             (cfg_ready),
        .cfg_index             (cfg_index),
        .cfg_data              (cfg_data)
    );

    initial clk = 1'b0;
    always #6 clk = ~clk;

    // Commands waiting to be sent and results still owed by the block.
    pdcm_pkg::cmd_t    pending_cmds[$];
    pdcm_pkg::result_t owed_results[$];
    int      mismatches;
    longint  cycle_no;

    // Predictor state.
    logic [63:0] iv_reg;
    logic [63:0] phase_reg;
    logic        sched_running;
    logic [63:0] next_dl;
    logic [63:0] anchor_mono;
    logic [63:0] anchor_unix;
    logic [63:0] last_start;
    logic [63:0] sched_cnt;
    logic [63:0] miss_cnt;
    logic [pdcm_pkg::V_W-1:0] win_data[2][pdcm_pkg::WIN_DEPTH];
    int win_fill[2];
    int win_head[2];

    function void win_push(int w, logic [63:0] v);
        win_data[w][win_head[w]] = v[pdcm_pkg::V_W-1:0];
        win_head[w] = (win_head[w] + 1) % pdcm_pkg::WIN_DEPTH;
        if (win_fill[w] < pdcm_pkg::WIN_DEPTH)
            win_fill[w]++;
    endfunction

    function automatic logic [pdcm_pkg::V_W-1:0] win_p95(int w);
        logic [pdcm_pkg::V_W-1:0] sorted[$];
        int n;
        int rank;
        n = win_fill[w];
        if (n == 0)
            return '0;
        for (int i = 0; i < n; i++)
            sorted.push_back(win_data[w][i]);
        sorted.sort();
        rank = (n * 95 + 99) / 100 - 1;
        return sorted[rank];
    endfunction

    function logic [63:0] sat40(logic [63:0] v);
        return (v > MASK40) ? MASK40 : v;
    endfunction

    function pdcm_pkg::result_t predict_cadence(pdcm_pkg::cmd_t c);
        pdcm_pkg::result_t r;
        logic [63:0] now;
        logic [63:0] act;
        logic [63:0] missed;
        logic [63:0] eff;
        logic [63:0] off;
        logic [63:0] err;
        now = {1'b0, c.now};
        act = {1'b0, c.actual};
        r = '0;
        case (c.op)
            pdcm_pkg::OP_START:
            begin
                sched_running = 1'b1;
                anchor_mono = now;
                anchor_unix = {1'b0, c.now_unix};
                next_dl = now + (phase_reg % iv_reg);
                last_start = '0;
                win_fill[JIT] = 0;
                win_head[JIT] = 0;
                win_fill[ERR] = 0;
                win_head[ERR] = 0;
                sched_cnt = '0;
                miss_cnt = '0;
            end
            pdcm_pkg::OP_STOP:
                sched_running = 1'b0;
            pdcm_pkg::OP_RESUME:
            begin
                if (sched_running)
                begin
                    anchor_mono = now;
                    anchor_unix = {1'b0, c.now_unix};
                    next_dl = now + iv_reg;
                    last_start = '0;
                end
            end
            default:
            begin
                if (sched_running && now >= next_dl)
                begin
                    missed = (now - next_dl) / iv_reg;
                    eff = next_dl + missed * iv_reg;
                    next_dl = eff + iv_reg;
                    r.due = 1'b1;
                    r.sched = eff[pdcm_pkg::T_W-1:0];
                    off = (eff >= anchor_mono) ? eff - anchor_mono : 64'd0;
                    r.sched_unix = (off > MASK63 - anchor_unix) ?
                                   MASK63[pdcm_pkg::T_W-1:0] :
                                   pdcm_pkg::T_W'(anchor_unix + off);
                    if (missed > SAT32)
                        missed = SAT32;
                    r.missed_now = missed[pdcm_pkg::C_W-1:0];
                    if (sched_cnt < SAT32)
                        sched_cnt++;
                    miss_cnt = (missed > SAT32 - miss_cnt) ? SAT32 : miss_cnt + missed;
                    r.jitter = sat40(now - eff);
                    win_push(JIT, sat40(now - eff));
                    if (last_start != 0)
                    begin
                        if (act >= last_start)
                            err = (act - last_start >= iv_reg) ? act - last_start - iv_reg
                                                               : iv_reg - (act - last_start);
                        else
                            err = last_start - act + iv_reg;
                        win_push(ERR, sat40(err));
                    end
                    last_start = act;
                end
            end
        endcase
        r.sched_total = sched_cnt[pdcm_pkg::C_W-1:0];
        r.missed_total = miss_cnt[pdcm_pkg::C_W-1:0];
        r.jitter_p95 = win_p95(JIT);
        r.err_p95 = win_p95(ERR);
        return r;
    endfunction

    // Sender: bursts of random length separated by random gaps.
    int burst_left;
    int gap_left;

    always @(posedge clk)
    begin
        cycle_no <= cycle_no + 1;
        if (rst_n && push && !full)
        begin
            owed_results.push_back(predict_cadence(pending_cmds[0]));
            void'(pending_cmds.pop_front());
            burst_left--;
            if (burst_left <= 0)
            begin
                burst_left = $urandom_range(1, 8);
                gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 20);
            end
        end
    end

    always @(negedge clk)
    begin
        if (!rst_n || pending_cmds.size() == 0)
            push <= 1'b0;
        else if (gap_left > 0)
        begin
            gap_left--;
            push <= 1'b0;
        end
        else
        begin
            push <= 1'b1;
            op <= pending_cmds[0].op;
            now_ns <= pending_cmds[0].now;
            now_unix_ns <= pending_cmds[0].now_unix;
            actual_start_unix_ns <= pending_cmds[0].actual;
        end
    end

    // Receiver: it steps in turn through four stall patterns, chosen from the cycle count.
    always @(negedge clk)
    begin
        case ((cycle_no / 256) % 4)
            0: pop <= 1'b1;
            1: pop <= $urandom_range(0, 1);
            2: pop <= ($urandom_range(0, 7) == 0);
            default: pop <= (cycle_no % 5 != 0);
        endcase
    end

    always @(posedge clk)
    begin
        pdcm_pkg::result_t got;
        pdcm_pkg::result_t want;
        if (rst_n && pop && !empty)
        begin
            got.due = due;
            got.sched = scheduled_ns;
            got.sched_unix = scheduled_unix_ns;
            got.missed_now = missed_now;
            got.sched_total = scheduled_total;
            got.missed_total = missed_total;
            got.jitter = jitter_ns;
            got.jitter_p95 = jitter_p95_ns;
            got.err_p95 = interval_error_p95_ns;
            if (owed_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result transaction at cycle %0d", cycle_no);
            end
            else
            begin
                want = owed_results.pop_front();
                if (got !== want)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $display("mismatch at cycle %0d", cycle_no);
                        $display({"  exp due=%0d sch=%h unix=%h miss=%h tot=%h",
                                  " mtot=%h jit=%h jp=%h ep=%h"},
                                 want.due, want.sched, want.sched_unix, want.missed_now,
                                 want.sched_total, want.missed_total, want.jitter,
                                 want.jitter_p95, want.err_p95);
                        $display({"  got due=%0d sch=%h unix=%h miss=%h tot=%h",
                                  " mtot=%h jit=%h jp=%h ep=%h"},
                                 got.due, got.sched, got.sched_unix, got.missed_now,
                                 got.sched_total, got.missed_total, got.jitter,
                                 got.jitter_p95, got.err_p95);
                    end
                end
            end
        end
    end

    function void add_cmd(logic [1:0] o, logic [63:0] t, logic [63:0] u, logic [63:0] a);
        pdcm_pkg::cmd_t c;
        c.op = o;
        c.now = t[pdcm_pkg::T_W-1:0];
        c.now_unix = u[pdcm_pkg::T_W-1:0];
        c.actual = a[pdcm_pkg::T_W-1:0];
        pending_cmds.push_back(c);
    endfunction

    function logic [63:0] rand_time();
        logic [63:0] v;
        v = {$urandom, $urandom};
        return v >> $urandom_range(1, 34);
    endfunction

    task automatic wait_idle();
        while (pending_cmds.size() != 0 || owed_results.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    task automatic write_reg(logic idx, logic [63:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value[pdcm_pkg::V_W-1:0];
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        if (idx == pdcm_pkg::REG_INTERVAL)
            iv_reg = (value[pdcm_pkg::V_W-1:0] < IV_FLOOR) ? IV_FLOOR
                                                           : {24'd0, value[pdcm_pkg::V_W-1:0]};
        else
            phase_reg = {24'd0, value[pdcm_pkg::V_W-1:0]};
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // One well-formed schedule: a start followed by polls near each deadline,
    // with early polls, skipped periods and stop/resume pairs mixed in.
    task automatic gen_schedule(int polls);
        logic [63:0] mono;
        logic [63:0] unix;
        logic [63:0] t;
        logic [63:0] now;
        logic [63:0] act;
        logic [63:0] eff;
        int r;
        mono = rand_time();
        if (mono > MASK63 - iv_reg * (polls + 4) * 8)
            mono = {32'd0, $urandom};
        unix = rand_time();
        add_cmd(pdcm_pkg::OP_START, mono, unix, rand_time());
        t = mono + phase_reg % iv_reg;
        for (int k = 0; k < polls; k++)
        begin
            r = $urandom_range(0, 15);
            if (r == 0 && t > mono)
                add_cmd(pdcm_pkg::OP_POLL, t - 1, rand_time(), rand_time());
            else if (r == 1)
                t = t + iv_reg * $urandom_range(1, 4);
            else if (r == 2)
            begin
                add_cmd(pdcm_pkg::OP_STOP, t, rand_time(), rand_time());
                add_cmd(pdcm_pkg::OP_POLL, t + iv_reg, rand_time(), rand_time());
                mono = t + iv_reg + 1;
                unix = (unix + iv_reg + 7) & MASK63;
                add_cmd(pdcm_pkg::OP_RESUME, mono, unix, rand_time());
                t = mono + iv_reg;
            end
            now = (r == 3) ? t : t + {$urandom, $urandom} % (iv_reg / 2);
            if (r == 4)
                act = '0;
            else if (r == 5)
                act = rand_time();
            else
                act = (unix + (now - mono) + $urandom_range(0, 2000)) & MASK63;
            add_cmd(pdcm_pkg::OP_POLL, now, rand_time(), act);
            eff = t + ((now - t) / iv_reg) * iv_reg;
            t = eff + iv_reg;
        end
    endtask

    initial
    begin
        #(2_000_000_000);
        $display("Verification failed");
        $finish;
    end

    initial
    begin
        rst_n = 1'b0;
        push = 1'b0;
        pop = 1'b0;
        op = pdcm_pkg::OP_START;
        now_ns = '0;
        now_unix_ns = '0;
        actual_start_unix_ns = '0;
        cfg_valid = 1'b0;
        cfg_index = pdcm_pkg::REG_INTERVAL;
        cfg_data = '0;
        mismatches = 0;
        cycle_no = 0;
        burst_left = 1;
        gap_left = 0;
        iv_reg = IV_FLOOR;
        phase_reg = '0;
        sched_running = 1'b0;
        next_dl = '0;
        anchor_mono = '0;
        anchor_unix = '0;
        last_start = '0;
        sched_cnt = '0;
        miss_cnt = '0;
        win_fill = '{0, 0};
        win_head = '{0, 0};
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed part at the reset configuration.
        add_cmd(pdcm_pkg::OP_POLL, 64'd0, 64'd0, 64'd0);             // poll before any start
        add_cmd(pdcm_pkg::OP_RESUME, 64'd100, 64'd100, 64'd0);       // resume while stopped
        add_cmd(pdcm_pkg::OP_STOP, 64'd200, 64'd0, 64'd0);
        add_cmd(pdcm_pkg::OP_START, 64'd0, 64'd0, 64'd0);
        add_cmd(pdcm_pkg::OP_POLL, 64'd0, 64'd0, 64'd0);             // zero start stamp
        add_cmd(pdcm_pkg::OP_POLL, 64'd500, 64'd0, 64'd0);           // not yet due
        add_cmd(pdcm_pkg::OP_POLL, 64'd1000000, 64'd0, 64'd1000);
        add_cmd(pdcm_pkg::OP_POLL, 64'd5500000, 64'd0, 64'd5000000); // three periods skipped
        add_cmd(pdcm_pkg::OP_POLL, 64'd6000000, 64'd0, 64'd10);      // stamp going backward
        add_cmd(pdcm_pkg::OP_POLL, MASK63, MASK63, MASK63);          // huge jump saturates
        add_cmd(pdcm_pkg::OP_POLL, MASK63, MASK63, MASK63);
        add_cmd(pdcm_pkg::OP_STOP, 64'd7000000, 64'd0, 64'd0);
        add_cmd(pdcm_pkg::OP_POLL, 64'd9000000, 64'd0, 64'd0);       // stopped, never due
        add_cmd(pdcm_pkg::OP_START, 64'd0, MASK63 - 5, MASK63);
        add_cmd(pdcm_pkg::OP_POLL, 64'd3000000, 64'd0, 64'd1);       // wall time saturates
        add_cmd(pdcm_pkg::OP_RESUME, 64'd3500000, 64'd42, 64'd0);
        add_cmd(pdcm_pkg::OP_POLL, 64'd4500000, 64'd0, 64'd7);
        add_cmd(pdcm_pkg::OP_POLL, 64'd5500001, 64'd0, 64'd1000008);
        add_cmd(pdcm_pkg::OP_START, MASK63, MASK63, 64'd0);
        add_cmd(pdcm_pkg::OP_POLL, MASK63, MASK63, MASK63);
        wait_idle();

        // Interval below the floor, largest phase.
        write_reg(pdcm_pkg::REG_INTERVAL, 64'd0);
        write_reg(pdcm_pkg::REG_PHASE, MASK40);
        gen_schedule(12);
        gen_schedule(10);
        wait_idle();
        write_reg(pdcm_pkg::REG_INTERVAL, 64'd999999);
        gen_schedule(8);
        wait_idle();

        // Largest interval, zero phase.
        write_reg(pdcm_pkg::REG_INTERVAL, MASK40);
        write_reg(pdcm_pkg::REG_PHASE, 64'd0);
        gen_schedule(15);
        gen_schedule(10);
        wait_idle();

        // One long schedule that wraps the jitter window.
        write_reg(pdcm_pkg::REG_INTERVAL, IV_FLOOR + 64'($urandom_range(0, 1000000)));
        write_reg(pdcm_pkg::REG_PHASE, {$urandom, $urandom} & MASK40);
        gen_schedule(530);
        wait_idle();

        for (int p = 0; p < 2; p++)
        begin
            case ($urandom_range(0, 3))
                0: write_reg(pdcm_pkg::REG_INTERVAL, 64'($urandom_range(0, 5000000)));
                1: write_reg(pdcm_pkg::REG_INTERVAL, 64'($urandom_range(1000000, 4000000)));
                2: write_reg(pdcm_pkg::REG_INTERVAL, {$urandom, $urandom} & MASK40);
                default: write_reg(pdcm_pkg::REG_INTERVAL, MASK40);
            endcase
            write_reg(pdcm_pkg::REG_PHASE, {$urandom, $urandom} & MASK40);
            for (int s = 0; s < 3; s++)
            begin
                gen_schedule($urandom_range(2, 12));
                add_cmd(2'($urandom_range(0, 3)), rand_time(), rand_time(), rand_time());
            end
            add_cmd(pdcm_pkg::OP_POLL, {$urandom, $urandom} & MASK63, {$urandom, $urandom},
                    {$urandom, $urandom});
            wait_idle();
        end

        repeat (200) @(posedge clk);
        if (mismatches == 0 && owed_results.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
